[rtl/usbsrd_pkg.sv]
// ---------------------------------------------------------------------------
// usbsrd_pkg: shared definitions of the standard request decoder
// Field widths, request and action codes, and the structs that pass between
// the decode logic, the stall bit bank and the top level.
// ---------------------------------------------------------------------------
package usbsrd_pkg;

	// Sizing of the endpoint table and of the string descriptor set.
	localparam int ENDPOINT_COUNT = 8;
	localparam int STRING_COUNT   = 5;

	// The stall state holds at most eight endpoints per direction.
	localparam int EP_LIMIT  = (ENDPOINT_COUNT < 8) ? ENDPOINT_COUNT : 8;
	localparam int STR_LIMIT = (STRING_COUNT < 8) ? STRING_COUNT : 8;

	localparam int TYPE_W   = 8;
	localparam int CODE_W   = 8;
	localparam int VALUE_W  = 16;
	localparam int INDEX_W  = 16;
	localparam int ACTION_W = 3;
	localparam int RLEN_W   = 2;
	localparam int BYTE_W   = 8;
	localparam int KIND_W   = 2;
	localparam int SNUM_W   = 3;
	localparam int STALL_W  = 16;
	localparam int BIT_W    = 4;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_CONFIGURATION = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERFACE     = 1'd1;

	// Standard request codes (bRequest).
	localparam logic [CODE_W-1:0] REQ_GET_STATUS     = 8'd0;
	localparam logic [CODE_W-1:0] REQ_CLEAR_FEATURE  = 8'd1;
	localparam logic [CODE_W-1:0] REQ_RESERVED_2     = 8'd2;
	localparam logic [CODE_W-1:0] REQ_SET_FEATURE    = 8'd3;
	localparam logic [CODE_W-1:0] REQ_RESERVED_4     = 8'd4;
	localparam logic [CODE_W-1:0] REQ_SET_ADDRESS    = 8'd5;
	localparam logic [CODE_W-1:0] REQ_GET_DESCRIPTOR = 8'd6;
	localparam logic [CODE_W-1:0] REQ_SET_DESCRIPTOR = 8'd7;
	localparam logic [CODE_W-1:0] REQ_GET_CONFIG     = 8'd8;
	localparam logic [CODE_W-1:0] REQ_SET_CONFIG     = 8'd9;
	localparam logic [CODE_W-1:0] REQ_GET_INTERFACE  = 8'd10;
	localparam logic [CODE_W-1:0] REQ_SET_INTERFACE  = 8'd11;
	localparam logic [CODE_W-1:0] REQ_SYNCH_FRAME    = 8'd12;

	// Request types (bmRequestType) that the decoder tells apart.
	localparam logic [TYPE_W-1:0] RT_DEV_OUT = 8'h00;
	localparam logic [TYPE_W-1:0] RT_EP_OUT  = 8'h02;
	localparam logic [TYPE_W-1:0] RT_DEV_IN  = 8'h80;
	localparam logic [TYPE_W-1:0] RT_IF_IN   = 8'h81;
	localparam logic [TYPE_W-1:0] RT_EP_IN   = 8'h82;

	// Descriptor types in the high byte of wValue.
	localparam logic [BYTE_W-1:0] DT_DEVICE = 8'd1;
	localparam logic [BYTE_W-1:0] DT_CONFIG = 8'd2;
	localparam logic [BYTE_W-1:0] DT_STRING = 8'd3;

	localparam logic [INDEX_W-1:0] LANG_NONE  = 16'h0000;
	localparam logic [INDEX_W-1:0] LANG_EN_US = 16'h0409;

	// Actions for endpoint zero.
	localparam logic [ACTION_W-1:0] ACT_ACK   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_STALL = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_REPLY = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_DESC  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_SOFT  = 3'd4;

	// Descriptor kinds.
	localparam logic [KIND_W-1:0] KIND_DEVICE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CONFIG = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LANG   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_STRING = 2'd3;

	// Endpoint whose toggles and stall bits set interface resets.
	localparam int TOG_EP = 2;
	localparam logic [BIT_W-1:0] TOG_OUT_BIT = 4'(TOG_EP);
	localparam logic [BIT_W-1:0] TOG_IN_BIT  = 4'(TOG_EP + 8);

	typedef struct packed {
		logic [TYPE_W-1:0]  request_type;
		logic [CODE_W-1:0]  request_code;
		logic [VALUE_W-1:0] request_value;
		logic [INDEX_W-1:0] request_index;
	} req_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [RLEN_W-1:0]   reply_length;
		logic [BYTE_W-1:0]   reply_first;
		logic [KIND_W-1:0]   descriptor_kind;
		logic [SNUM_W-1:0]   string_number;
		logic                toggle_reset;
	} result_t;

	// Change to the stall bits caused by one request.
	typedef struct packed {
		logic             set;
		logic             clr;
		logic [BIT_W-1:0] idx;
		logic             tog_clr;
	} stall_upd_t;

	// Stall bits that can ever be set: endpoint zero's shared bit and the
	// OUT and IN bits of every endpoint below the limit.
	function automatic logic [STALL_W-1:0] stall_used_mask();
		logic [STALL_W-1:0] m;
		m = '0;
		for (int b = 0; b < STALL_W; b++) begin
			if (b == 0) begin
				m[b] = 1'b1;
			end else if ((b % 8) != 0 && (b % 8) < EP_LIMIT) begin
				m[b] = 1'b1;
			end
		end
		return m;
	endfunction

endpackage

[rtl/usbsrd_req_if.sv]
// ---------------------------------------------------------------------------
// usbsrd_req_if: setup packet channel
// Valid/ready channel that carries the four fields of one setup packet.
// ---------------------------------------------------------------------------
interface usbsrd_req_if
	import usbsrd_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic [TYPE_W-1:0]  request_type;
	logic [CODE_W-1:0]  request_code;
	logic [VALUE_W-1:0] request_value;
	logic [INDEX_W-1:0] request_index;

	modport source (
		output valid, request_type, request_code, request_value, request_index,
		input  ready
	);
	modport sink (
		input  valid, request_type, request_code, request_value, request_index,
		output ready
	);
endinterface

[rtl/usbsrd_rsp_if.sv]
// ---------------------------------------------------------------------------
// usbsrd_rsp_if: endpoint zero action channel
// Valid/ready channel that carries the action decided for one setup packet.
// ---------------------------------------------------------------------------
interface usbsrd_rsp_if
	import usbsrd_pkg::*;
	;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [RLEN_W-1:0]   reply_length;
	logic [BYTE_W-1:0]   reply_first;
	logic [KIND_W-1:0]   descriptor_kind;
	logic [SNUM_W-1:0]   string_number;
	logic                toggle_reset;

	modport source (
		output valid, action, reply_length, reply_first, descriptor_kind,
		       string_number, toggle_reset,
		input  ready
	);
	modport sink (
		input  valid, action, reply_length, reply_first, descriptor_kind,
		       string_number, toggle_reset,
		output ready
	);
endinterface

[rtl/usbsrd_decode.sv]
// ---------------------------------------------------------------------------
// usbsrd_decode: standard request decode
// Combinational decode of one registered setup packet into an action and
// the change it makes to the stall bits.
// ---------------------------------------------------------------------------
module usbsrd_decode
	import usbsrd_pkg::*;
(
	input  req_t               req,
	input  logic [STALL_W-1:0] stall_bits,
	input  logic [BYTE_W-1:0]  configuration_number,
	input  logic [BYTE_W-1:0]  interface_number,
	output result_t            res,
	output stall_upd_t         upd
);

	logic [3:0]        ep_num;
	logic              ep_ok;
	logic [BIT_W-1:0]  ep_bit;
	logic [BYTE_W-1:0] dtype;
	logic [BYTE_W-1:0] didx;
	logic [BYTE_W-1:0] didx_m1;
	logic              str_ok;

	// Endpoint address: bit 7 is the direction, bits 3..0 the number.
	assign ep_num = req.request_index[3:0];
	assign ep_ok  = {1'b0, ep_num} < 5'(EP_LIMIT);
	assign ep_bit = (ep_num == 4'd0) ? 4'd0 : {req.request_index[7], ep_num[2:0]};

	assign dtype   = req.request_value[15:8];
	assign didx    = req.request_value[7:0];
	assign didx_m1 = didx - 8'd1;
	assign str_ok  = (didx != 8'd0) && (didx <= 8'(STR_LIMIT));

	always_comb begin
		res     = '0;
		upd     = '0;
		upd.idx = ep_bit;
		case (req.request_code)
			REQ_GET_STATUS: begin
				if (req.request_type inside {RT_DEV_IN, RT_IF_IN}) begin
					res.action       = ACT_REPLY;
					res.reply_length = 2'd2;
				end else if (req.request_type == RT_EP_IN && ep_ok) begin
					res.action       = ACT_REPLY;
					res.reply_length = 2'd2;
					res.reply_first  = {7'd0, stall_bits[ep_bit]};
				end else begin
					res.action = ACT_STALL;
				end
			end
			REQ_CLEAR_FEATURE: begin
				if (req.request_type == RT_DEV_OUT) begin
					res.action = ACT_STALL;
				end else if (req.request_type == RT_EP_OUT) begin
					if (req.request_value == '0 && ep_ok) begin
						upd.clr = 1'b1;
					end else begin
						res.action = ACT_STALL;
					end
				end
			end
			REQ_SET_FEATURE: begin
				if (req.request_type == RT_EP_OUT) begin
					if (req.request_value == '0 && ep_ok) begin
						upd.set = 1'b1;
					end else begin
						res.action = ACT_STALL;
					end
				end
			end
			REQ_RESERVED_2, REQ_RESERVED_4, REQ_SET_DESCRIPTOR: begin
				res.action = ACT_STALL;
			end
			REQ_SET_ADDRESS, REQ_SET_CONFIG, REQ_SYNCH_FRAME: begin
				res.action = ACT_ACK;
			end
			REQ_GET_DESCRIPTOR: begin
				if (dtype == DT_DEVICE) begin
					res.action          = ACT_DESC;
					res.descriptor_kind = KIND_DEVICE;
				end else if (dtype == DT_CONFIG) begin
					res.action          = ACT_DESC;
					res.descriptor_kind = KIND_CONFIG;
				end else if (dtype == DT_STRING && req.request_index == LANG_NONE) begin
					res.action          = ACT_DESC;
					res.descriptor_kind = KIND_LANG;
				end else if (dtype == DT_STRING && req.request_index == LANG_EN_US
						&& str_ok) begin
					res.action          = ACT_DESC;
					res.descriptor_kind = KIND_STRING;
					res.string_number   = didx_m1[SNUM_W-1:0];
				end else begin
					res.action = ACT_STALL;
				end
			end
			REQ_GET_CONFIG: begin
				res.action       = ACT_REPLY;
				res.reply_length = 2'd1;
				res.reply_first  = configuration_number;
			end
			REQ_GET_INTERFACE: begin
				res.action       = ACT_REPLY;
				res.reply_length = 2'd1;
				res.reply_first  = interface_number;
			end
			REQ_SET_INTERFACE: begin
				res.toggle_reset = 1'b1;
				upd.tog_clr      = 1'b1;
			end
			default: begin
				res.action = ACT_SOFT;
			end
		endcase
	end

endmodule

[rtl/usbsrd_stall_bank.sv]
// ---------------------------------------------------------------------------
// usbsrd_stall_bank: endpoint stall bits
// Holds one stall bit per endpoint and direction and applies the change
// that each decoded request makes.
// ---------------------------------------------------------------------------
module usbsrd_stall_bank
	import usbsrd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  stall_upd_t         upd,
	output logic [STALL_W-1:0] stall_bits
);

	localparam logic [STALL_W-1:0] USED_MASK = stall_used_mask();

	logic [STALL_W-1:0] stall_q;
	logic [STALL_W-1:0] stall_d;

	always_comb begin
		stall_d = stall_q;
		if (upd.set) begin
			stall_d[upd.idx] = 1'b1;
		end
		if (upd.clr) begin
			stall_d[upd.idx] = 1'b0;
		end
		if (upd.tog_clr) begin
			stall_d[TOG_OUT_BIT] = 1'b0;
			stall_d[TOG_IN_BIT]  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_q <= '0;
		end else begin
			stall_q <= stall_d;
		end
	end

	assign stall_bits = stall_q;

`ifndef SYNTHESIS
	a_unused_bits_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(stall_q & ~USED_MASK) == '0)
		else $error("stall bit set for an endpoint that does not exist");

	a_set_takes: assert property (@(posedge clk) disable iff (!arst_n)
		upd.set |=> stall_q[$past(upd.idx)])
		else $error("set feature did not set the stall bit");

	a_tog_clears: assert property (@(posedge clk) disable iff (!arst_n)
		upd.tog_clr |=> !stall_q[TOG_OUT_BIT] && !stall_q[TOG_IN_BIT])
		else $error("set interface left an endpoint 2 stall bit set");
`endif

endmodule

[rtl/usb_standard_request_decoder_core.sv]
// ---------------------------------------------------------------------------
// usb_standard_request_decoder_core: endpoint zero standard request decoder
// Use: a setup packet enters as one word on the req channel (request_type,
// request_code, request_value, request_index); the action for endpoint zero
// leaves as one word on the rsp channel. Every packet gives exactly one
// action word, in order.
// Order: a word accepted from req sits in the input register and is decoded
// there; its action is registered in the output register once that register
// is free, and is shown on rsp from there.
// Throughput: one word per cycle while rsp is ready. The decode is a single
// pass of shallow logic between the input register and the output register,
// and the stall bits are updated at the same edge that loads the output
// register, so the next packet already sees them.
// Stalls: when rsp is held off, the output register keeps its word and the
// input register keeps the next one; req.ready drops only when both are full.
// Reset (arst_n low): both registers empty, every stall bit cleared, the
// configuration number 1, the interface number 0. The cfg port writes them;
// the user must use it only while idle; the block itself does not enforce it.
// ---------------------------------------------------------------------------
module usb_standard_request_decoder_core
	import usbsrd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	usbsrd_req_if.sink           req,
	usbsrd_rsp_if.source         rsp,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data
);

	// Configuration registers.
	logic [BYTE_W-1:0] configuration_number_q;
	logic [BYTE_W-1:0] interface_number_q;

	// Input register: one setup packet waiting for decode.
	logic valid_s1;
	req_t req_s1;

	// Output register: one action waiting to be taken.
	logic    valid_s2;
	result_t res_s2;

	logic               out_free;
	logic               advance;
	logic               in_take;
	result_t            res_d;
	stall_upd_t         upd_d;
	stall_upd_t         upd_gated;
	logic [STALL_W-1:0] stall_bits;

	// The output register can take a new word when it is empty or is being
	// emptied in this cycle; the input register then moves forward.
	assign out_free  = !valid_s2 || rsp.ready;
	assign advance   = valid_s1 && out_free;
	assign req.ready = !valid_s1 || advance;
	assign in_take   = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			configuration_number_q <= 8'd1;
			interface_number_q     <= 8'd0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_CONFIGURATION: configuration_number_q <= cfg_data;
				CFG_INTERFACE:     interface_number_q     <= cfg_data;
				default:           ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1.request_type  <= req.request_type;
			req_s1.request_code  <= req.request_code;
			req_s1.request_value <= req.request_value;
			req_s1.request_index <= req.request_index;
		end
	end

	usbsrd_decode u_decode (
		.req                  (req_s1),
		.stall_bits           (stall_bits),
		.configuration_number (configuration_number_q),
		.interface_number     (interface_number_q),
		.res                  (res_d),
		.upd                  (upd_d)
	);

	// A request changes the stall bits only when its action is committed.
	always_comb begin
		upd_gated         = upd_d;
		upd_gated.set     = upd_d.set && advance;
		upd_gated.clr     = upd_d.clr && advance;
		upd_gated.tog_clr = upd_d.tog_clr && advance;
	end

	usbsrd_stall_bank u_stall_bank (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (upd_gated),
		.stall_bits (stall_bits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign rsp.valid           = valid_s2;
	assign rsp.action          = res_s2.action;
	assign rsp.reply_length    = res_s2.reply_length;
	assign rsp.reply_first     = res_s2.reply_first;
	assign rsp.descriptor_kind = res_s2.descriptor_kind;
	assign rsp.string_number   = res_s2.string_number;
	assign rsp.toggle_reset    = res_s2.toggle_reset;

`ifndef SYNTHESIS
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("decoded word did not reach the output register");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(req_s1))
		else $error("input register lost a word while the output was full");

	a_toggle_is_ack: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.toggle_reset |-> rsp.action == ACT_ACK)
		else $error("toggle reset with an action other than acknowledge");

	a_len_only_reply: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.reply_length != 2'd0 |-> rsp.action == ACT_REPLY)
		else $error("reply length given without a reply action");
`endif

endmodule

[bench/usb_standard_request_decoder_core_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// usb_standard_request_decoder_core_test: self-checking bench of the decoder
// Setup packets go in on the req channel and action words come back on the
// rsp channel. A behavioral decoder inside the bench keeps its own copy of the
// stall bits and of the two registers, and works out the action word for each
// packet as it is accepted. A checker compares every action word, field by
// field, with the oldest prediction. Directed packets come first, then
// random ones under idling, back-pressure and register changes.
// ---------------------------------------------------------------------------
module usb_standard_request_decoder_core_test;
	import usbsrd_pkg::*;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 7;
	localparam int IDLE_PERCENT   = 11;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int PRINT_LIMIT    = 40;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_data;

	usbsrd_req_if req_ch ();
	usbsrd_rsp_if rsp_ch ();

	usb_standard_request_decoder_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Bench copy of the decoder state. It starts at the reset values and
	// moves along in the order in which packets are accepted.
	logic [STALL_W-1:0] endpoint_halts = '0;
	logic [BYTE_W-1:0]  config_value   = 8'd1;
	logic [BYTE_W-1:0]  alt_setting    = 8'd0;

	// Action words predicted for accepted packets, oldest first.
	result_t pending_actions [$];
	result_t want;

	int  mismatch_count = 0;
	int  words_checked  = 0;
	int  quiet_cycles   = 0;

	// Knobs shared by the stimulus and the receiving side.
	bit  sender_pauses   = 1'b1;
	bit  receiver_pauses = 1'b1;
	bit  hold_request    = 1'b0;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// -----------------------------------------------------------------------
	// Behavioral decoder
	// -----------------------------------------------------------------------

	// Maps the endpoint address in the low byte of wIndex to its stall bit.
	// Bits 6..4 play no part. Endpoint zero shares bit 0 for both directions.
	// Endpoints at or above the table size have no bit at all.
	function automatic logic halt_slot(input logic [7:0] addr, output logic [BIT_W-1:0] slot);
		logic [3:0] num;
		num = addr[3:0];
		slot = '0;
		if (num >= ENDPOINT_COUNT || num >= 8) begin
			return 1'b0;
		end
		slot = (num == 4'd0) ? '0 : {addr[7], num[2:0]};
		return 1'b1;
	endfunction

	// Works out the action word for one setup packet and applies any change
	// that the packet makes to the stall bits.
	function automatic result_t decode_setup(input req_t r);
		result_t          res;
		logic [BIT_W-1:0] slot;
		logic             known;
		logic [7:0]       dtype;
		logic [7:0]       didx;
		res = '0;
		res.action = ACT_ACK;
		known = halt_slot(r.request_index[7:0], slot);
		dtype = r.request_value[15:8];
		didx = r.request_value[7:0];
		case (r.request_code)
		REQ_GET_STATUS: begin
			// Device and interface status are two zero bytes; endpoint
			// status carries the stall bit in the first byte.
			if (r.request_type == RT_DEV_IN || r.request_type == RT_IF_IN) begin
				res.action = ACT_REPLY;
				res.reply_length = 2'd2;
			end else if (r.request_type == RT_EP_IN && known) begin
				res.action = ACT_REPLY;
				res.reply_length = 2'd2;
				res.reply_first = {7'd0, endpoint_halts[slot]};
			end else begin
				res.action = ACT_STALL;
			end
		end
		REQ_CLEAR_FEATURE: begin
			// Device recipient stalls, endpoint halt clears one bit, any
			// other recipient is acknowledged and ignored.
			if (r.request_type == RT_DEV_OUT) begin
				res.action = ACT_STALL;
			end else if (r.request_type == RT_EP_OUT) begin
				if (r.request_value == '0 && known) begin
					endpoint_halts[slot] = 1'b0;
				end else begin
					res.action = ACT_STALL;
				end
			end
		end
		REQ_SET_FEATURE: begin
			if (r.request_type == RT_EP_OUT) begin
				if (r.request_value == '0 && known) begin
					endpoint_halts[slot] = 1'b1;
				end else begin
					res.action = ACT_STALL;
				end
			end
		end
		REQ_RESERVED_2, REQ_RESERVED_4, REQ_SET_DESCRIPTOR: begin
			res.action = ACT_STALL;
		end
		REQ_SET_ADDRESS, REQ_SET_CONFIG, REQ_SYNCH_FRAME: begin
		end
		REQ_GET_DESCRIPTOR: begin
			res.action = ACT_DESC;
			if (dtype == DT_DEVICE) begin
				res.descriptor_kind = KIND_DEVICE;
			end else if (dtype == DT_CONFIG) begin
				res.descriptor_kind = KIND_CONFIG;
			end else if (dtype == DT_STRING && r.request_index == LANG_NONE) begin
				// Language zero always means the language table.
				res.descriptor_kind = KIND_LANG;
			end else if (dtype == DT_STRING && r.request_index == LANG_EN_US &&
			             didx >= 1 && didx <= STR_LIMIT) begin
				res.descriptor_kind = KIND_STRING;
				res.string_number = 3'(didx - 8'd1);
			end else begin
				res.action = ACT_STALL;
			end
		end
		REQ_GET_CONFIG: begin
			res.action = ACT_REPLY;
			res.reply_length = 2'd1;
			res.reply_first = config_value;
		end
		REQ_GET_INTERFACE: begin
			res.action = ACT_REPLY;
			res.reply_length = 2'd1;
			res.reply_first = alt_setting;
		end
		REQ_SET_INTERFACE: begin
			res.toggle_reset = 1'b1;
			endpoint_halts[TOG_OUT_BIT] = 1'b0;
			endpoint_halts[TOG_IN_BIT] = 1'b0;
		end
		default: begin
			res.action = ACT_SOFT;
		end
		endcase
		return res;
	endfunction

	// -----------------------------------------------------------------------
	// Stimulus helpers
	// -----------------------------------------------------------------------

	// Offers one packet, with random idle cycles in front of it, and records
	// the predicted action word at the edge where it is accepted. Valid stays
	// high on return so that back-to-back words need no gap.
	task automatic send_setup(input req_t r);
		while (sender_pauses && $urandom_range(99) < IDLE_PERCENT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.request_type <= r.request_type;
		req_ch.request_code <= r.request_code;
		req_ch.request_value <= r.request_value;
		req_ch.request_index <= r.request_index;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		pending_actions.push_back(decode_setup(r));
	endtask

	// Stops offering and waits until every predicted word has come back.
	// Never call this twice in a row without a send in between.
	task automatic wait_for_actions();
		req_ch.valid <= 1'b0;
		while (pending_actions.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Writes the configuration register, then the interface register. The block must be idle.
	task automatic write_registers(input logic [BYTE_W-1:0] conf, input logic [BYTE_W-1:0] alt);
		cfg_write <= 1'b1;
		cfg_index <= CFG_CONFIGURATION;
		cfg_data <= conf;
		@(posedge clk);
		config_value = conf;
		cfg_index <= CFG_INTERFACE;
		cfg_data <= alt;
		@(posedge clk);
		alt_setting = alt;
		cfg_write <= 1'b0;
	endtask

	// Random setup packet. Most are shaped like real requests with random
	// content, so that the stall bits and the descriptor checks are reached
	// often; the rest are noise across every bit of every field.
	function automatic req_t random_setup();
		req_t r;
		r = {$urandom, 16'($urandom)};
		if ($urandom_range(99) < 75) begin
			r.request_code = 8'($urandom_range(0, REQ_SYNCH_FRAME + 1));
			case ($urandom_range(0, 5))
			0: r.request_type = RT_DEV_OUT;
			1: r.request_type = RT_EP_OUT;
			2: r.request_type = RT_DEV_IN;
			3: r.request_type = RT_IF_IN;
			4: r.request_type = RT_EP_IN;
			default: ;
			endcase
			case (r.request_code)
			REQ_GET_STATUS, REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
				// Endpoint numbers just past the table are kept in play.
				if ($urandom_range(99) < 70) begin
					r.request_value = '0;
				end
				r.request_index = {($urandom_range(99) < 80) ? 8'h00 : 8'($urandom),
				                   r.request_index[7:4], 4'($urandom_range(0, 9))};
			end
			REQ_GET_DESCRIPTOR: begin
				case ($urandom_range(0, 4))
				0: r.request_value[15:8] = DT_DEVICE;
				1: r.request_value[15:8] = DT_CONFIG;
				2, 3: r.request_value[15:8] = DT_STRING;
				default: ;
				endcase
				r.request_value[7:0] = 8'($urandom_range(0, STRING_COUNT + 2));
				case ($urandom_range(0, 3))
				0: r.request_index = LANG_NONE;
				1, 2: r.request_index = LANG_EN_US;
				default: ;
				endcase
			end
			default: ;
			endcase
		end
		return r;
	endfunction

	// -----------------------------------------------------------------------
	// Tests
	// -----------------------------------------------------------------------

	// Get status, set and clear feature on the stall bits, and set interface
	// clearing the endpoint 2 bits.
	task automatic test_status_and_features();
		send_setup('{RT_DEV_IN, REQ_GET_STATUS, 16'h0000, 16'h0000});
		send_setup('{RT_DEV_OUT, REQ_GET_STATUS, 16'h0000, 16'h0000});
		send_setup('{RT_EP_OUT, REQ_SET_FEATURE, 16'h0000, 16'h0081});
		send_setup('{RT_EP_IN, REQ_GET_STATUS, 16'h0000, 16'h0081});
		// Endpoint zero with the ignored address bits set.
		send_setup('{RT_EP_OUT, REQ_SET_FEATURE, 16'h0000, 16'h00F0});
		send_setup('{RT_EP_IN, REQ_GET_STATUS, 16'h0000, 16'h0080});
		// Endpoint fifteen lies past the table and must stall.
		send_setup('{RT_EP_OUT, REQ_SET_FEATURE, 16'h0000, 16'hFFFF});
		send_setup('{RT_EP_OUT, REQ_SET_FEATURE, 16'h0001, 16'h0001});
		send_setup('{RT_DEV_OUT, REQ_SET_FEATURE, 16'hFFFF, 16'h0000});
		send_setup('{RT_DEV_OUT, REQ_CLEAR_FEATURE, 16'h0000, 16'h0000});
		send_setup('{RT_EP_OUT, REQ_CLEAR_FEATURE, 16'h0000, 16'h0081});
		send_setup('{RT_EP_OUT, REQ_SET_FEATURE, 16'h0000, 16'h0082});
		send_setup('{RT_IF_IN, REQ_SET_INTERFACE, 16'h0000, 16'h0000});
		send_setup('{RT_EP_IN, REQ_GET_STATUS, 16'h0000, 16'h0082});
	endtask

	// Every descriptor kind, both ends of the string range, and the strings
	// that must stall.
	task automatic test_descriptor_selection();
		send_setup('{RT_DEV_IN, REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, LANG_NONE});
		send_setup('{RT_DEV_IN, REQ_GET_DESCRIPTOR, {DT_CONFIG, 8'h00}, LANG_NONE});
		send_setup('{RT_DEV_IN, REQ_GET_DESCRIPTOR, {DT_STRING, 8'hFF}, LANG_NONE});
		send_setup('{RT_DEV_IN, REQ_GET_DESCRIPTOR, {DT_STRING, 8'h01}, LANG_EN_US});
		send_setup('{RT_DEV_IN, REQ_GET_DESCRIPTOR, {DT_STRING, 8'(STRING_COUNT)}, LANG_EN_US});
		send_setup('{RT_DEV_IN, REQ_GET_DESCRIPTOR, {DT_STRING, 8'h00}, LANG_EN_US});
		send_setup('{RT_DEV_IN, REQ_GET_DESCRIPTOR, {DT_STRING, 8'(STRING_COUNT + 1)},
		             LANG_EN_US});
		send_setup('{RT_DEV_IN, REQ_GET_DESCRIPTOR, {DT_STRING, 8'h01}, 16'h0407});
		send_setup('{RT_DEV_IN, REQ_GET_DESCRIPTOR, 16'hFF01, LANG_EN_US});
	endtask

	// The remaining request codes, the two registers at their reset values,
	// and a packet with every bit set, which goes to software.
	task automatic test_other_requests();
		send_setup('{RT_DEV_OUT, REQ_RESERVED_2, 16'h0000, 16'h0000});
		send_setup('{RT_DEV_OUT, REQ_RESERVED_4, 16'h0000, 16'h0000});
		send_setup('{RT_DEV_OUT, REQ_SET_DESCRIPTOR, 16'h0000, 16'h0000});
		send_setup('{RT_DEV_OUT, REQ_SET_ADDRESS, 16'h007F, 16'h0000});
		send_setup('{RT_DEV_OUT, REQ_SET_CONFIG, 16'h0001, 16'h0000});
		send_setup('{RT_EP_IN, REQ_SYNCH_FRAME, 16'h0000, 16'h0081});
		send_setup('{RT_DEV_IN, REQ_GET_CONFIG, 16'h0000, 16'h0000});
		send_setup('{RT_IF_IN, REQ_GET_INTERFACE, 16'h0000, 16'h0000});
		send_setup('{8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF});
	endtask

	// Both registers at their extremes and at a random value, each read back
	// through get configuration and get interface.
	task automatic test_configuration_registers();
		wait_for_actions();
		write_registers(8'h00, 8'hFF);
		send_setup('{RT_DEV_IN, REQ_GET_CONFIG, 16'h0000, 16'h0000});
		send_setup('{RT_IF_IN, REQ_GET_INTERFACE, 16'h0000, 16'h0000});
		wait_for_actions();
		write_registers(8'hFF, 8'h00);
		send_setup('{RT_DEV_IN, REQ_GET_CONFIG, 16'h0000, 16'h0000});
		send_setup('{RT_IF_IN, REQ_GET_INTERFACE, 16'h0000, 16'h0000});
		wait_for_actions();
		write_registers(8'($urandom), 8'($urandom));
		send_setup('{RT_IF_IN, REQ_GET_INTERFACE, 16'h0000, 16'h0000});
		send_setup('{RT_DEV_IN, REQ_GET_CONFIG, 16'h0000, 16'h0000});
	endtask

	// Random packets after a fresh random register setting.
	task automatic test_random_requests(input int count);
		wait_for_actions();
		write_registers(8'($urandom), 8'($urandom));
		repeat (count) begin
			send_setup(random_setup());
		end
	endtask

	// A long run with neither side idling, so that words go through at the
	// full rate of one per cycle.
	task automatic test_steady_stream(input int count);
		sender_pauses = 1'b0;
		receiver_pauses = 1'b0;
		repeat (count) begin
			send_setup(random_setup());
		end
		sender_pauses = 1'b1;
		receiver_pauses = 1'b1;
	endtask

	// The receiver holds off for a long stretch while packets keep coming,
	// so both internal registers fill and req.ready must drop.
	task automatic test_output_backpressure(input int count);
		hold_request = 1'b1;
		repeat (count) begin
			send_setup(random_setup());
		end
	endtask

	// -----------------------------------------------------------------------
	// Receiving side
	// -----------------------------------------------------------------------

	// Drives rsp.ready: random idle cycles when allowed, and a counted
	// hold-off whenever a test asks for one.
	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				rsp_ch.ready <= !(receiver_pauses && $urandom_range(99) < IDLE_PERCENT);
				@(posedge clk);
			end
		end
	end

	// Prints one line per mismatch, up to a limit, and counts every one.
	task automatic report_mismatch(input string what, input int unsigned got,
	                               input int unsigned wanted);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT) begin
			$display("%0t ns: word %0d: %s: got %0d, expected %0d", $time, words_checked,
			         what, got, wanted);
		end
	endtask

	// Compares each accepted action word with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_actions.size() == 0) begin
				report_mismatch("action word with nothing expected", rsp_ch.action, 0);
			end else begin
				want = pending_actions.pop_front();
				if (rsp_ch.action !== want.action) begin
					report_mismatch("action", rsp_ch.action, want.action);
				end
				if (rsp_ch.reply_length !== want.reply_length) begin
					report_mismatch("reply_length", rsp_ch.reply_length, want.reply_length);
				end
				if (rsp_ch.reply_first !== want.reply_first) begin
					report_mismatch("reply_first", rsp_ch.reply_first, want.reply_first);
				end
				if (rsp_ch.descriptor_kind !== want.descriptor_kind) begin
					report_mismatch("descriptor_kind", rsp_ch.descriptor_kind,
					                want.descriptor_kind);
				end
				if (rsp_ch.string_number !== want.string_number) begin
					report_mismatch("string_number", rsp_ch.string_number, want.string_number);
				end
				if (rsp_ch.toggle_reset !== want.toggle_reset) begin
					report_mismatch("toggle_reset", rsp_ch.toggle_reset, want.toggle_reset);
				end
			end
			words_checked++;
		end
	end

	// Ends the run if neither channel moves a word for too long. The limit
	// is well above the longest hold-off the receiver ever applies.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Test sequence
	// -----------------------------------------------------------------------
	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.request_type <= '0;
		req_ch.request_code <= '0;
		req_ch.request_value <= '0;
		req_ch.request_index <= '0;
		cfg_write <= 1'b0;
		cfg_index <= CFG_CONFIGURATION;
		cfg_data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_status_and_features();
		test_descriptor_selection();
		test_other_requests();
		test_configuration_registers();
		test_random_requests(300);
		test_steady_stream(200);
		test_output_backpressure(40);
		test_random_requests(350);

		// Let every outstanding word come back, then allow a few more cycles
		// for anything the block should not have produced.
		wait_for_actions();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[files.f]
rtl/usbsrd_pkg.sv
rtl/usbsrd_req_if.sv
rtl/usbsrd_rsp_if.sv
rtl/usbsrd_decode.sv
rtl/usbsrd_stall_bank.sv
rtl/usb_standard_request_decoder_core.sv
bench/usb_standard_request_decoder_core_test.sv
